// ===== rtl/core/gbr_pkg.sv =====
// ----------------------------------------------------------------------------
// gbr_pkg: shared types and constants of the grid escape router
// Grid geometry, cell and queue entry layouts, and the cell index and neighbor step functions.
// ----------------------------------------------------------------------------
`default_nettype none

package gbr_pkg;

  localparam int MAX_SIDE = 64;
  localparam int GRID_N   = MAX_SIDE + 2;
  localparam int CELLS    = GRID_N * GRID_N;
  localparam int CELL_AW  = $clog2(CELLS);
  localparam int COORD_W  = $clog2(GRID_N + 1);
  localparam int DIST_W   = 13;
  localparam int SIDE_W   = 7;

  typedef logic [1:0]         kind_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [CELL_AW-1:0] cidx_t;

  localparam kind_t KIND_OUT  = 2'd0;
  localparam kind_t KIND_IN   = 2'd1;
  localparam kind_t KIND_OBST = 2'd2;

  localparam dist_t DIST_MAX = '1;

  // Commands
  localparam logic [1:0] FUNC_INIT  = 2'd0;
  localparam logic [1:0] FUNC_OBST  = 2'd1;
  localparam logic [1:0] FUNC_ROUTE = 2'd2;

  // Neighbor directions in probe order
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Configuration register index (byte address bit 2)
  localparam logic CFG_IDX_SIDE = 1'b0;

  typedef struct packed {
    kind_t kind;
    dist_t hops;
  } cell_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
    dist_t  hops;
  } qent_t;

  typedef struct packed {
    logic   ok;
    coord_t row;
    coord_t col;
  } nb_t;

  localparam int CELL_W = $bits(cell_t);
  localparam int QENT_W = $bits(qent_t);

  // Linear cell index: row * GRID_N + col
  function automatic cidx_t cell_idx(input coord_t r, input coord_t c);
    cidx_t acc;
    acc = '0;
    for (int b = 0; b < COORD_W; b++) begin
      if (r[b]) begin
        acc = acc + cidx_t'(GRID_N << b);
      end
    end
    return acc + cidx_t'(c);
  endfunction

  // Neighbor of (r, c) in direction d, bounded to an h x h area
  function automatic nb_t nb_step(input coord_t r, input coord_t c,
                                  input logic [1:0] d, input coord_t h);
    nb_t n;
    n.ok  = 1'b1;
    n.row = r;
    n.col = c;
    case (d)
      DIR_RIGHT: begin
        n.col = c + coord_t'(1);
        n.ok  = ((c + coord_t'(1)) < h);
      end
      DIR_UP: begin
        n.row = r - coord_t'(1);
        n.ok  = (r != '0);
      end
      DIR_LEFT: begin
        n.col = c - coord_t'(1);
        n.ok  = (c != '0);
      end
      default: begin
        n.row = r + coord_t'(1);
        n.ok  = ((r + coord_t'(1)) < h);
      end
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gbr_ram.sv =====
// ----------------------------------------------------------------------------
// gbr_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write beat
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, hold when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gbr_cfg.sv =====
// ----------------------------------------------------------------------------
// gbr_cfg: configuration register bank
// Holds the interior side length and presents its clamped value.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_cfg
  import gbr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output logic      [SIDE_W-1:0] side_eff
);

  logic [SIDE_W-1:0] side_r;

  // take a write beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_W'(MAX_SIDE);
    end else if (psel && penable && pwrite && (paddr[2] == CFG_IDX_SIDE)) begin
      side_r <= pwdata[SIDE_W-1:0];
    end
  end

  // clamp the side into 1..MAX_SIDE
  always_comb begin
    if (side_r == '0) begin
      side_eff = SIDE_W'(1);
    end else if (side_r > SIDE_W'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = side_r;
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_SIDE) ? {{(32-SIDE_W){1'b0}}, side_r} : 32'd0;
  assign pready = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/core/gbr_engine.sv =====
// ----------------------------------------------------------------------------
// gbr_engine: command sequencer of the grid escape router
// Builds the grid, marks obstacles, clears distances, runs the breadth-first
// search over the cell store and the frontier queue, and traces the path back.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_engine
  import gbr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [SIDE_W-1:0]  side_eff,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_func,
  input  wire logic [5:0]         in_row,
  input  wire logic [5:0]         in_col,
  output logic                    out_valid,
  output logic                    out_found,
  output logic      [12:0]        out_path_cells,
  output logic                    out_bad_coord,
  // cell store
  output logic                    m_we,
  output cidx_t                   m_waddr,
  output logic      [CELL_W-1:0]  m_wdata,
  output logic                    m_re,
  output cidx_t                   m_raddr,
  input  wire logic [CELL_W-1:0]  m_rdata,
  // frontier queue
  output logic                    q_we,
  output cidx_t                   q_waddr,
  output logic      [QENT_W-1:0]  q_wdata,
  output logic                    q_re,
  output cidx_t                   q_raddr,
  input  wire logic [QENT_W-1:0]  q_rdata
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DISPATCH = 4'd1;
  localparam logic [3:0] ST_INIT     = 4'd2;
  localparam logic [3:0] ST_CLEAR    = 4'd3;
  localparam logic [3:0] ST_POP      = 4'd4;
  localparam logic [3:0] ST_PROBE    = 4'd5;
  localparam logic [3:0] ST_LAST     = 4'd6;
  localparam logic [3:0] ST_TB_ISSUE = 4'd7;
  localparam logic [3:0] ST_TB_EVAL  = 4'd8;

  localparam logic [CELL_AW:0] CELLS_W = (CELL_AW+1)'(CELLS);

  logic [3:0]       state_r, state_nxt;
  logic             rst_sweep_r, rst_sweep_nxt;
  logic [1:0]       func_r, func_nxt;
  logic [5:0]       row_r, row_nxt;
  logic [5:0]       col_r, col_nxt;
  logic [CELL_AW:0] sw_addr_r, sw_addr_nxt;
  coord_t           sw_row_r, sw_row_nxt;
  coord_t           sw_col_r, sw_col_nxt;
  cidx_t            head_r, head_nxt;
  logic [CELL_AW:0] tail_r, tail_nxt;
  logic [1:0]       dir_r, dir_nxt;
  logic             pend_r, pend_nxt;
  coord_t           pend_row_r, pend_row_nxt;
  coord_t           pend_col_r, pend_col_nxt;
  cidx_t            pend_idx_r, pend_idx_nxt;
  dist_t            tb_t_r, tb_t_nxt;
  coord_t           tb_row_r, tb_row_nxt;
  coord_t           tb_col_r, tb_col_nxt;
  logic [1:0]       tb_dir_r, tb_dir_nxt;
  logic [12:0]      tb_cnt_r, tb_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [12:0]      out_cells_r, out_cells_nxt;
  logic             out_bad_r, out_bad_nxt;

  coord_t h_cur;
  coord_t start_row;
  coord_t start_col;
  cidx_t  start_idx;
  logic   coord_bad;
  kind_t  init_kind;
  cell_t  rd_cell;
  qent_t  cur;
  dist_t  nd;
  nb_t    nb_probe;
  nb_t    nb_tb;
  logic   hit;
  cidx_t  clr_waddr;

  assign h_cur     = rst_sweep_r ? coord_t'(GRID_N) : (coord_t'(side_eff) + coord_t'(2));
  assign start_row = coord_t'(row_r) + coord_t'(1);
  assign start_col = coord_t'(col_r) + coord_t'(1);
  assign start_idx = cell_idx(start_row, start_col);
  assign coord_bad = (SIDE_W'(row_r) >= side_eff) || (SIDE_W'(col_r) >= side_eff);
  assign init_kind = ((sw_row_r >= coord_t'(1)) && ((sw_row_r + coord_t'(2)) <= h_cur) &&
                      (sw_col_r >= coord_t'(1)) && ((sw_col_r + coord_t'(2)) <= h_cur))
                     ? KIND_IN : KIND_OUT;
  assign rd_cell   = cell_t'(m_rdata);
  assign cur       = qent_t'(q_rdata);
  assign nd        = cur.hops + dist_t'(1);
  assign nb_probe  = nb_step(cur.row, cur.col, dir_r, h_cur);
  assign nb_tb     = nb_step(tb_row_r, tb_col_r, tb_dir_r, h_cur);
  assign clr_waddr = sw_addr_r[CELL_AW-1:0] - cidx_t'(1);

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    rst_sweep_nxt = rst_sweep_r;
    func_nxt      = func_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    sw_addr_nxt   = sw_addr_r;
    sw_row_nxt    = sw_row_r;
    sw_col_nxt    = sw_col_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    dir_nxt       = dir_r;
    pend_nxt      = pend_r;
    pend_row_nxt  = pend_row_r;
    pend_col_nxt  = pend_col_r;
    pend_idx_nxt  = pend_idx_r;
    tb_t_nxt      = tb_t_r;
    tb_row_nxt    = tb_row_r;
    tb_col_nxt    = tb_col_r;
    tb_dir_nxt    = tb_dir_r;
    tb_cnt_nxt    = tb_cnt_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_cells_nxt = out_cells_r;
    out_bad_nxt   = out_bad_r;
    m_we          = 1'b0;
    m_waddr       = '0;
    m_wdata       = '0;
    m_re          = 1'b0;
    m_raddr       = '0;
    q_we          = 1'b0;
    q_waddr       = '0;
    q_wdata       = '0;
    q_re          = 1'b0;
    q_raddr       = '0;
    hit           = 1'b0;

    // evaluate the pending neighbor probe
    if (((state_r == ST_PROBE) || (state_r == ST_LAST)) && pend_r &&
        (rd_cell.kind != KIND_OBST)) begin
      if (rd_cell.hops > nd) begin
        m_we    = 1'b1;
        m_waddr = pend_idx_r;
        m_wdata = {rd_cell.kind, nd};
        if (tail_r < CELLS_W) begin
          q_we     = 1'b1;
          q_waddr  = tail_r[CELL_AW-1:0];
          q_wdata  = {pend_row_r, pend_col_r, nd};
          tail_nxt = tail_r + (CELL_AW+1)'(1);
        end
      end
      if (rd_cell.kind == KIND_OUT) begin
        hit        = 1'b1;
        tb_t_nxt   = (rd_cell.hops > nd) ? nd : rd_cell.hops;
        tb_row_nxt = pend_row_r;
        tb_col_nxt = pend_col_r;
        tb_dir_nxt = DIR_RIGHT;
        tb_cnt_nxt = 13'd1;
        state_nxt  = ST_TB_ISSUE;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt  = in_func;
          row_nxt   = in_row;
          col_nxt   = in_col;
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        out_found_nxt = 1'b0;
        out_cells_nxt = '0;
        out_bad_nxt   = 1'b0;
        if (func_r == FUNC_INIT) begin
          sw_addr_nxt = '0;
          sw_row_nxt  = '0;
          sw_col_nxt  = '0;
          state_nxt   = ST_INIT;
        end else if ((func_r == FUNC_OBST) || (func_r == FUNC_ROUTE)) begin
          if (coord_bad) begin
            out_bad_nxt   = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else if (func_r == FUNC_OBST) begin
            m_we          = 1'b1;
            m_waddr       = start_idx;
            m_wdata       = {KIND_OBST, DIST_MAX};
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            // seed the queue with the start cell, then clear distances
            q_we        = 1'b1;
            q_waddr     = '0;
            q_wdata     = {start_row, start_col, dist_t'(0)};
            head_nxt    = '0;
            tail_nxt    = (CELL_AW+1)'(1);
            sw_addr_nxt = '0;
            state_nxt   = ST_CLEAR;
          end
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_INIT: begin
        // write one cell a cycle, raster order
        m_we    = 1'b1;
        m_waddr = sw_addr_r[CELL_AW-1:0];
        m_wdata = {init_kind, DIST_MAX};
        if (sw_addr_r == (CELLS_W - (CELL_AW+1)'(1))) begin
          if (rst_sweep_r) begin
            rst_sweep_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end else begin
          sw_addr_nxt = sw_addr_r + (CELL_AW+1)'(1);
          if (sw_col_r == coord_t'(GRID_N - 1)) begin
            sw_col_nxt = '0;
            sw_row_nxt = sw_row_r + coord_t'(1);
          end else begin
            sw_col_nxt = sw_col_r + coord_t'(1);
          end
        end
      end

      ST_CLEAR: begin
        // read entry i, write back entry i-1 with its distance reset
        if (sw_addr_r < CELLS_W) begin
          m_re    = 1'b1;
          m_raddr = sw_addr_r[CELL_AW-1:0];
        end
        if (sw_addr_r != '0) begin
          m_we    = 1'b1;
          m_waddr = clr_waddr;
          m_wdata = {rd_cell.kind, (clr_waddr == start_idx) ? dist_t'(0) : DIST_MAX};
        end
        if (sw_addr_r == CELLS_W) begin
          state_nxt = ST_POP;
        end else begin
          sw_addr_nxt = sw_addr_r + (CELL_AW+1)'(1);
        end
      end

      ST_POP: begin
        if ({1'b0, head_r} == tail_r) begin
          // frontier empty: no escape
          out_found_nxt = 1'b0;
          out_cells_nxt = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          q_re      = 1'b1;
          q_raddr   = head_r;
          head_nxt  = head_r + cidx_t'(1);
          dir_nxt   = DIR_RIGHT;
          pend_nxt  = 1'b0;
          state_nxt = ST_PROBE;
        end
      end

      ST_PROBE: begin
        if (!hit) begin
          pend_nxt     = nb_probe.ok;
          pend_row_nxt = nb_probe.row;
          pend_col_nxt = nb_probe.col;
          pend_idx_nxt = cell_idx(nb_probe.row, nb_probe.col);
          if (nb_probe.ok) begin
            m_re    = 1'b1;
            m_raddr = cell_idx(nb_probe.row, nb_probe.col);
          end
          dir_nxt = dir_r + 2'd1;
          if (dir_r == DIR_DOWN) begin
            state_nxt = ST_LAST;
          end
        end
      end

      ST_LAST: begin
        if (!hit) begin
          state_nxt = ST_POP;
        end
      end

      ST_TB_ISSUE: begin
        if (tb_t_r == '0) begin
          out_found_nxt = 1'b1;
          out_cells_nxt = tb_cnt_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (nb_tb.ok) begin
          m_re         = 1'b1;
          m_raddr      = cell_idx(nb_tb.row, nb_tb.col);
          pend_row_nxt = nb_tb.row;
          pend_col_nxt = nb_tb.col;
          pend_idx_nxt = cell_idx(nb_tb.row, nb_tb.col);
          state_nxt    = ST_TB_EVAL;
        end else begin
          tb_dir_nxt = tb_dir_r + 2'd1;
          if (tb_dir_r == DIR_DOWN) begin
            tb_t_nxt = tb_t_r - dist_t'(1);
          end
        end
      end

      ST_TB_EVAL: begin
        // step onto a neighbor one closer and mark it outside
        if (rd_cell.hops == (tb_t_r - dist_t'(1))) begin
          tb_row_nxt = pend_row_r;
          tb_col_nxt = pend_col_r;
          m_we       = 1'b1;
          m_waddr    = pend_idx_r;
          m_wdata    = {KIND_OUT, rd_cell.hops};
          tb_cnt_nxt = tb_cnt_r + 13'd1;
        end
        tb_dir_nxt = tb_dir_r + 2'd1;
        if (tb_dir_r == DIR_DOWN) begin
          tb_t_nxt = tb_t_r - dist_t'(1);
        end
        state_nxt = ST_TB_ISSUE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      rst_sweep_r <= 1'b1;
      sw_addr_r   <= '0;
      sw_row_r    <= '0;
      sw_col_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      dir_r       <= '0;
      pend_r      <= 1'b0;
      tb_dir_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rst_sweep_r <= rst_sweep_nxt;
      sw_addr_r   <= sw_addr_nxt;
      sw_row_r    <= sw_row_nxt;
      sw_col_r    <= sw_col_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      dir_r       <= dir_nxt;
      pend_r      <= pend_nxt;
      tb_dir_r    <= tb_dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_col_r  <= pend_col_nxt;
    pend_idx_r  <= pend_idx_nxt;
    tb_t_r      <= tb_t_nxt;
    tb_row_r    <= tb_row_nxt;
    tb_col_r    <= tb_col_nxt;
    tb_cnt_r    <= tb_cnt_nxt;
    out_found_r <= out_found_nxt;
    out_cells_r <= out_cells_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_path_cells = out_cells_r;
  assign out_bad_coord  = out_bad_r;

  // the queue never pops past its fill point
  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, head_r} <= tail_r))
    else $error("frontier head passed tail");

  // a result beat is never followed by another in the next cycle
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result beats");

  // no store write while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!m_we && !q_we))
    else $error("store written while idle");

  // a found path never comes with a bad coordinate or a zero length
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (!out_bad_coord && (out_path_cells != '0)))
    else $error("found path with bad coordinate or zero length");

endmodule

`default_nettype wire

// ===== rtl/core/grid_bfs_escape_router.sv =====
// ----------------------------------------------------------------------------
// grid_bfs_escape_router: breadth-first escape router over a bordered grid
// Steps: obstacle, bad-coordinate and unused commands answer from dispatch; grid
//   rebuild sweeps every cell; route seeds the queue and clears distances, then
//   pops each visited cell from the queue, probes four neighbors, then traces back.
// One command at a time; busy is high until its result beat, which cannot stall.
// After reset the grid is built with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_bfs_escape_router
  import gbr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [5:0]  in_row,
  input  wire logic [5:0]  in_col,
  output logic             out_valid,
  output logic             out_found,
  output logic      [12:0] out_path_cells,
  output logic             out_bad_coord,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [SIDE_W-1:0] side_eff;
  logic              m_we, m_re, q_we, q_re;
  cidx_t             m_waddr, m_raddr, q_waddr, q_raddr;
  logic [CELL_W-1:0] m_wdata, m_rdata;
  logic [QENT_W-1:0] q_wdata, q_rdata;

  // register bank
  gbr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .side_eff (side_eff)
  );

  // sequencer
  gbr_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .side_eff       (side_eff),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_row         (in_row),
    .in_col         (in_col),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_path_cells (out_path_cells),
    .out_bad_coord  (out_bad_coord),
    .m_we           (m_we),
    .m_waddr        (m_waddr),
    .m_wdata        (m_wdata),
    .m_re           (m_re),
    .m_raddr        (m_raddr),
    .m_rdata        (m_rdata),
    .q_we           (q_we),
    .q_waddr        (q_waddr),
    .q_wdata        (q_wdata),
    .q_re           (q_re),
    .q_raddr        (q_raddr),
    .q_rdata        (q_rdata)
  );

  // cell store: kind and distance per cell
  gbr_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // frontier queue
  gbr_ram #(.WIDTH(QENT_W), .DEPTH(CELLS)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

endmodule

`default_nettype wire
